// ----- rtl/core/odd_pkg.sv -----
// Shared types and constants of the debounced orientation detector.
package odd_pkg;

	// Orientation class codes; the quarter turns 0 to 3 use the low two bits.
	localparam logic [2:0] CLS_UP   = 3'd4;
	localparam logic [2:0] CLS_DOWN = 3'd5;
	localparam logic [2:0] CLS_UNK  = 3'd6;

	localparam int TIME_W   = 48;
	localparam int AXIS_W   = 16;
	localparam int COS2_W   = 17;
	localparam int STABLE_W = 24;
	localparam int SQ_W     = 32;
	localparam int PROD_W   = COS2_W + SQ_W;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_NORM_MIN    = 3'd0,
		REG_NORM_MAX    = 3'd1,
		REG_FACE_ENTER  = 3'd2,
		REG_FACE_EXIT   = 3'd3,
		REG_ROT_KEEP    = 3'd4,
		REG_STABLE_TIME = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [15:0]         norm_min;
		logic [15:0]         norm_max;
		logic [COS2_W-1:0]   face_enter_cos2;
		logic [COS2_W-1:0]   face_exit_cos2;
		logic [COS2_W-1:0]   rotation_keep_cos2;
		logic [STABLE_W-1:0] stable_time_us;
	} cfg_t;

	// One classified item as handed from the front end to the back end.
	typedef struct packed {
		logic              clr;
		logic              unk;
		logic              face_enter;
		logic              face_exit;
		logic              zneg;
		logic [1:0]        quarter;
		logic [3:0]        keep;
		logic [TIME_W-1:0] time_us;
	} qent_t;

	// Front end sequencer states.
	typedef enum logic [2:0] {
		F_IDLE,
		F_SQZ,
		F_NORM,
		F_FACE,
		F_PUSH
	} front_state_t;

endpackage

// ----- rtl/core/odd_front.sv -----
// Front end: squares and threshold products on two shared multipliers, then the tests.
module odd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_clr,
	input  logic signed [odd_pkg::AXIS_W-1:0] in_x,
	input  logic signed [odd_pkg::AXIS_W-1:0] in_y,
	input  logic signed [odd_pkg::AXIS_W-1:0] in_z,
	input  logic                              in_ok,
	input  logic [odd_pkg::TIME_W-1:0]        in_time,
	input  odd_pkg::cfg_t                     cfg,
	output logic                              push_valid,
	input  logic                              push_ready,
	output odd_pkg::qent_t                    push_data
);

	odd_pkg::front_state_t state_q, state_d;

	logic signed [odd_pkg::AXIS_W-1:0] x_q, y_q, z_q;
	logic                              ok_q, clr_q;
	logic [odd_pkg::TIME_W-1:0]        time_q;
	logic [odd_pkg::SQ_W-1:0]          x2_q, y2_q, z2_q, n2_q, nmin2_q, nmax2_q;
	logic [odd_pkg::PROD_W-1:0]        keep_prod_q, enter_prod_q, exit_prod_q;

	logic [odd_pkg::AXIS_W-1:0]  abs_in_x, abs_in_y, abs_z;
	logic [odd_pkg::COS2_W-1:0]  opa_a, opa_b;
	logic [odd_pkg::SQ_W-1:0]    opb_a, opb_b;
	logic [odd_pkg::PROD_W-1:0]  prod_a, prod_b;
	logic                        accept;

	logic signed [odd_pkg::AXIS_W:0] up_a, up_b;
	logic [odd_pkg::PROD_W-1:0]      z2_sh, x2_sh, y2_sh;
	logic                            keep_x, keep_y, x_le0, x_ge0, y_le0, y_ge0;

	function automatic logic [1:0] round_quarter(input logic signed [16:0] a,
			input logic signed [16:0] b);
		logic [1:0] k;
		if (a == 17'sd0 && b == 17'sd0) begin
			k = 2'd2;
		end else if (b > 17'sd0 && -b <= a && a < b) begin
			k = 2'd0;
		end else if (a > 17'sd0 && -a < b && b <= a) begin
			k = 2'd1;
		end else if (b < 17'sd0 && b < a && a <= -b) begin
			k = 2'd2;
		end else begin
			k = 2'd3;
		end
		return k;
	endfunction

	assign abs_in_x = in_x[15] ? (~in_x + 16'd1) : in_x;
	assign abs_in_y = in_y[15] ? (~in_y + 16'd1) : in_y;
	assign abs_z    = z_q[15] ? (~z_q + 16'd1) : z_q;
	assign accept   = in_valid && in_ready;

	assign prod_a = odd_pkg::PROD_W'(opa_a) * odd_pkg::PROD_W'(opb_a);
	assign prod_b = odd_pkg::PROD_W'(opa_b) * odd_pkg::PROD_W'(opb_b);

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		push_valid = 1'b0;
		opa_a      = {1'b0, abs_in_x};
		opb_a      = 32'(abs_in_x);
		opa_b      = {1'b0, abs_in_y};
		opb_b      = 32'(abs_in_y);
		case (state_q)
			odd_pkg::F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = odd_pkg::F_SQZ;
				end
			end
			odd_pkg::F_SQZ: begin
				opa_a   = {1'b0, abs_z};
				opb_a   = 32'(abs_z);
				opa_b   = cfg.rotation_keep_cos2;
				opb_b   = x2_q + y2_q;
				state_d = odd_pkg::F_NORM;
			end
			odd_pkg::F_NORM: begin
				opa_a   = {1'b0, cfg.norm_min};
				opb_a   = 32'(cfg.norm_min);
				opa_b   = {1'b0, cfg.norm_max};
				opb_b   = 32'(cfg.norm_max);
				state_d = odd_pkg::F_FACE;
			end
			odd_pkg::F_FACE: begin
				opa_a   = cfg.face_enter_cos2;
				opb_a   = n2_q;
				opa_b   = cfg.face_exit_cos2;
				opb_b   = n2_q;
				state_d = odd_pkg::F_PUSH;
			end
			odd_pkg::F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					in_ready = 1'b1;
					state_d  = in_valid ? odd_pkg::F_SQZ : odd_pkg::F_IDLE;
				end
			end
			default: state_d = odd_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= odd_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= in_x;
			y_q    <= in_y;
			z_q    <= in_z;
			ok_q   <= in_ok;
			clr_q  <= in_clr;
			time_q <= in_time;
			x2_q   <= prod_a[odd_pkg::SQ_W-1:0];
			y2_q   <= prod_b[odd_pkg::SQ_W-1:0];
		end
		case (state_q)
			odd_pkg::F_SQZ: begin
				z2_q        <= prod_a[odd_pkg::SQ_W-1:0];
				keep_prod_q <= prod_b;
			end
			odd_pkg::F_NORM: begin
				nmin2_q <= prod_a[odd_pkg::SQ_W-1:0];
				nmax2_q <= prod_b[odd_pkg::SQ_W-1:0];
				n2_q    <= x2_q + y2_q + z2_q;
			end
			odd_pkg::F_FACE: begin
				enter_prod_q <= prod_a;
				exit_prod_q  <= prod_b;
			end
			default: ;
		endcase
	end

	// The up direction is the negated x, y pair.
	assign up_a = -{x_q[15], x_q};
	assign up_b = -{y_q[15], y_q};

	assign z2_sh = {1'b0, z2_q, 16'h0000};
	assign x2_sh = {1'b0, x2_q, 16'h0000};
	assign y2_sh = {1'b0, y2_q, 16'h0000};

	assign keep_x = x2_sh >= keep_prod_q;
	assign keep_y = y2_sh >= keep_prod_q;
	assign x_le0  = x_q[15] || (x_q == 16'sd0);
	assign x_ge0  = !x_q[15];
	assign y_le0  = y_q[15] || (y_q == 16'sd0);
	assign y_ge0  = !y_q[15];

	always_comb begin
		push_data.clr        = clr_q;
		push_data.unk        = !ok_q || (n2_q < nmin2_q) || (n2_q > nmax2_q);
		push_data.face_enter = z2_sh > enter_prod_q;
		push_data.face_exit  = z2_sh > exit_prod_q;
		push_data.zneg       = z_q[15];
		push_data.quarter    = round_quarter(up_a, up_b);
		push_data.keep[0]    = y_le0 && keep_y;
		push_data.keep[1]    = x_le0 && keep_x;
		push_data.keep[2]    = y_ge0 && keep_y;
		push_data.keep[3]    = x_ge0 && keep_x;
		push_data.time_us    = time_q;
	end

endmodule

// ----- rtl/core/odd_queue.sv -----
// Short first-in first-out queue between the front end and the back end.
module odd_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  odd_pkg::qent_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output odd_pkg::qent_t out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	odd_pkg::qent_t mem [DEPTH];

	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign do_push   = in_valid && in_ready;
	assign do_pop    = out_valid && out_ready;
	assign out_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/odd_back.sv -----
// Back end: hysteresis selection, debounce timing and the result register.
module odd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  odd_pkg::qent_t               pop_data,
	input  logic [odd_pkg::STABLE_W-1:0] stable_time_us,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   orientation,
	output logic                         changed
);

	logic [2:0]                 rep_q, cand_q, out_cls_q;
	logic [odd_pkg::TIME_W-1:0] start_q;
	logic                       out_valid_q, out_chg_q;

	logic                       pop, face_pass, new_cand, elapsed_ok, promote;
	logic [2:0]                 next_cls;
	logic [odd_pkg::TIME_W-1:0] diff;

	assign pop_ready = !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		face_pass = (rep_q == odd_pkg::CLS_UP || rep_q == odd_pkg::CLS_DOWN)
			? pop_data.face_exit : pop_data.face_enter;
		if (pop_data.unk) begin
			next_cls = odd_pkg::CLS_UNK;
		end else if (face_pass) begin
			next_cls = pop_data.zneg ? odd_pkg::CLS_UP : odd_pkg::CLS_DOWN;
		end else if (!rep_q[2] && pop_data.keep[rep_q[1:0]]) begin
			next_cls = rep_q;
		end else begin
			next_cls = {1'b0, pop_data.quarter};
		end
		diff       = pop_data.time_us - start_q;
		new_cand   = next_cls != cand_q;
		// A fresh candidate has zero elapsed time.
		elapsed_ok = new_cand ? (stable_time_us == '0)
			: (diff >= odd_pkg::TIME_W'(stable_time_us));
		promote    = (next_cls != odd_pkg::CLS_UNK) && (next_cls != rep_q) && elapsed_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q       <= odd_pkg::CLS_UNK;
			cand_q      <= odd_pkg::CLS_UNK;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (pop_data.clr) begin
					rep_q  <= odd_pkg::CLS_UNK;
					cand_q <= odd_pkg::CLS_UNK;
				end else begin
					cand_q <= next_cls;
					if (new_cand) begin
						start_q <= pop_data.time_us;
					end
					if (promote) begin
						rep_q <= next_cls;
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (pop_data.clr) begin
				out_cls_q <= odd_pkg::CLS_UNK;
				out_chg_q <= 1'b0;
			end else begin
				out_cls_q <= promote ? next_cls : rep_q;
				out_chg_q <= promote;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign orientation = out_cls_q;
	assign changed     = out_chg_q;

endmodule

// ----- rtl/core/orientation_detector_debounced_top.sv -----
// Top level of the debounced orientation detector: ports, configuration and the two halves.
//
//  channel   direction  handshake         payload
//  s_*       in         s_tvalid/tready   tdata: accel_x, accel_y, accel_z, read_ok, time_us
//                                         tuser: op
//  m_*       out        m_tvalid/tready   tdata: orientation, changed
//  cfg_*     in         cfg_we            cfg_index, cfg_data
//
// The front end takes a new item only once it has handed the last one on: the two shared
// 17 x 32 bit multipliers are used in four steps (x and y squares at accept, z square and
// rotation product, magnitude limits, face products); a last step hands the item to the
// queue and is at the same time the accept step of the next item. The back end retires one
// item per cycle into its output register while that register is empty or being read.
// Reset clears the reported and candidate class to unknown and the candidate start time to
// zero. A stalled output fills the queue first; only then does the front end stop accepting
// items.
module orientation_detector_debounced_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// Fields from bit 0: accel_x[15:0], accel_y[31:16], accel_z[47:32], read_ok[48],
	// time_us[96:49], then zero fill.
	input  logic [103:0] s_tdata,
	// Fields from bit 0: op.
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// Fields from bit 0: orientation[2:0], changed[3], then zero fill.
	output logic [7:0]   m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	odd_pkg::cfg_t  cfg_q;
	odd_pkg::qent_t push_data, pop_data;
	logic           push_valid, push_ready, pop_valid, pop_ready;
	logic [2:0]     orientation;
	logic           changed;

	// Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.norm_min           <= 16'd2048;
			cfg_q.norm_max           <= 16'd6144;
			cfg_q.face_enter_cos2    <= 17'd43974;
			cfg_q.face_exit_cos2     <= 17'd32768;
			cfg_q.rotation_keep_cos2 <= 17'd16384;
			cfg_q.stable_time_us     <= 24'd300000;
		end else if (cfg_we) begin
			case (cfg_index)
				odd_pkg::REG_NORM_MIN:    cfg_q.norm_min           <= cfg_data[15:0];
				odd_pkg::REG_NORM_MAX:    cfg_q.norm_max           <= cfg_data[15:0];
				odd_pkg::REG_FACE_ENTER:  cfg_q.face_enter_cos2    <= cfg_data[16:0];
				odd_pkg::REG_FACE_EXIT:   cfg_q.face_exit_cos2     <= cfg_data[16:0];
				odd_pkg::REG_ROT_KEEP:    cfg_q.rotation_keep_cos2 <= cfg_data[16:0];
				odd_pkg::REG_STABLE_TIME: cfg_q.stable_time_us     <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end computes every test that does not depend on the reported class.
	odd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_clr     (s_tuser),
		.in_x       (s_tdata[15:0]),
		.in_y       (s_tdata[31:16]),
		.in_z       (s_tdata[47:32]),
		.in_ok      (s_tdata[48]),
		.in_time    (s_tdata[96:49]),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	odd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_data   (push_data),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_data  (pop_data)
	);

	// The back end owns the reported class, the candidate and its start time.
	odd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_data       (pop_data),
		.stable_time_us (cfg_q.stable_time_us),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.orientation    (orientation),
		.changed        (changed)
	);

	assign m_tdata = {4'b0000, changed, orientation};

endmodule

// ----- verif/orientation_detector_debounced_top_test.sv -----
// Self-checking testbench for the debounced orientation detector top level.
`timescale 1ns / 100ps

module orientation_detector_debounced_top_test;

	// Quarter-turn classes share the code space with the face and unknown classes.
	localparam logic [2:0] CLS_ROT0 = 3'd0;
	localparam logic [2:0] CLS_ROT1 = 3'd1;
	localparam logic [2:0] CLS_ROT2 = 3'd2;
	localparam logic [2:0] CLS_ROT3 = 3'd3;

	localparam logic OP_CLASSIFY = 1'b0;
	localparam logic OP_CLEAR    = 1'b1;

	// Cycles to let pass once the last expected item is back, and the hard stop of the run.
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int MAX_PRINTED  = 100;

	// Poses used to build well-formed runs of samples.
	localparam int POSE_UP   = 4;
	localparam int POSE_DOWN = 5;

	typedef struct {
		logic               op;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic               read_ok;
		logic [47:0]        stamp_us;
	} sample_item_t;

	typedef struct {
		logic [2:0] orientation;
		logic       changed;
	} orient_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// Fields from bit 0: accel_x, accel_y, accel_z, read_ok, time_us, then zero fill.
	logic [103:0]        s_tdata = '0;
	// Fields from bit 0: op.
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// Fields from bit 0: orientation, changed, then zero fill.
	logic [7:0]          m_tdata;
	logic                cfg_we = 1'b0;
	odd_pkg::reg_index_t cfg_index = odd_pkg::REG_NORM_MIN;
	logic [23:0]         cfg_data = '0;

	orientation_detector_debounced_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// The testbench keeps its own copy of the registers, starting from the reset values.
	odd_pkg::cfg_t shadow_cfg = '{norm_min: 16'd2048, norm_max: 16'd6144,
		face_enter_cos2: 17'd43974, face_exit_cos2: 17'd32768,
		rotation_keep_cos2: 17'd16384, stable_time_us: 24'd300000};

	// Debounce state of the predictor, matching the block after reset.
	logic [2:0]  pred_reported = odd_pkg::CLS_UNK;
	logic [2:0]  pred_candidate = odd_pkg::CLS_UNK;
	logic [47:0] pred_cand_start = '0;

	sample_item_t   sample_pending[$];
	orient_result_t orient_expected[$];
	sample_item_t   drive_item;

	logic [47:0] clock_us;
	logic        calm = 1'b0;
	int          send_gap = 0;
	int          stall_gap = 0;
	int          err_count = 0;
	int          cycle_count = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		err_count++;
		if (err_count <= MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	// Classifies one valid sample against the currently reported class. All products are
	// formed in 64 bits, which holds every square and every Q16 threshold product exactly.
	function automatic logic [2:0] classify_tilt(sample_item_t s, logic [2:0] cur);
		longint x, y, z, a, b, d;
		longint unsigned z2, n2, h2, dd, lo, hi, th, keep;
		x = s.ax;
		y = s.ay;
		z = s.az;
		z2 = z * z;
		n2 = longint'(x * x) + longint'(y * y) + z2;
		lo = shadow_cfg.norm_min;
		hi = shadow_cfg.norm_max;
		if (n2 < lo * lo || n2 > hi * hi)
			return odd_pkg::CLS_UNK;

		// Leaving a face position uses the looser exit threshold.
		th = (cur == odd_pkg::CLS_UP || cur == odd_pkg::CLS_DOWN) ? shadow_cfg.face_exit_cos2
			: shadow_cfg.face_enter_cos2;
		if ((z2 << 16) > th * n2)
			return (z < 0) ? odd_pkg::CLS_UP : odd_pkg::CLS_DOWN;

		// The up direction is the negated x-y projection.
		a = -x;
		b = -y;
		if (cur <= CLS_ROT3) begin
			case (cur)
				CLS_ROT0: d = b;
				CLS_ROT1: d = a;
				CLS_ROT2: d = -b;
				default:  d = -a;
			endcase
			h2 = a * a + b * b;
			dd = d * d;
			keep = shadow_cfg.rotation_keep_cos2;
			if (d >= 0 && (dd << 16) >= keep * h2)
				return cur;
		end

		// Rounding to the nearest quarter turn; diagonals move on to the next turn.
		if (a == 0 && b == 0)
			return CLS_ROT2;
		if (b > 0 && -b <= a && a < b)
			return CLS_ROT0;
		if (a > 0 && -a < b && b <= a)
			return CLS_ROT1;
		if (b < 0 && b < a && a <= -b)
			return CLS_ROT2;
		return CLS_ROT3;
	endfunction

	// Advances the debounce state by one accepted item and returns the result it must give.
	function automatic orient_result_t predict_orientation(sample_item_t s);
		orient_result_t r;
		logic [2:0]     next;
		logic [47:0]    elapsed;
		r.changed = 1'b0;
		if (s.op == OP_CLEAR) begin
			// A clear forgets both classes but keeps the candidate start time.
			pred_reported = odd_pkg::CLS_UNK;
			pred_candidate = odd_pkg::CLS_UNK;
		end else begin
			next = odd_pkg::CLS_UNK;
			if (s.read_ok)
				next = classify_tilt(s, pred_reported);
			if (next != pred_candidate) begin
				pred_candidate = next;
				pred_cand_start = s.stamp_us;
			end
			// The elapsed time is taken modulo 2^48, so a wrapped timestamp still counts.
			elapsed = s.stamp_us - pred_cand_start;
			if (pred_candidate != odd_pkg::CLS_UNK && pred_candidate != pred_reported &&
				elapsed >= shadow_cfg.stable_time_us) begin
				pred_reported = pred_candidate;
				r.changed = 1'b1;
			end
		end
		r.orientation = pred_reported;
		return r;
	endfunction

	// Sender. An item stays on the bus until it is taken; the expected result is worked out
	// at the very edge that accepts it. After some items the sender pauses before the next.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				orient_expected.push_back(predict_orientation(drive_item));
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (sample_pending.size() != 0) begin
					drive_item = sample_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, drive_item.stamp_us, drive_item.read_ok,
						drive_item.az, drive_item.ay, drive_item.ax};
					s_tuser <= drive_item.op;
					if (!calm && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 8);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Each result is compared with the oldest expectation; tready drops in bursts
	// at random so that stalls fall on every stage of the pipeline.
	always @(posedge clk) begin
		orient_result_t exp_r;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (orient_expected.size() == 0) begin
					report_mismatch($sformatf("result %0d/%0d with nothing expected",
						m_tdata[2:0], m_tdata[3]));
				end else begin
					exp_r = orient_expected.pop_front();
					if (m_tdata[2:0] !== exp_r.orientation)
						report_mismatch($sformatf("orientation %0d, expected %0d",
							m_tdata[2:0], exp_r.orientation));
					if (m_tdata[3] !== exp_r.changed)
						report_mismatch($sformatf("changed %0b, expected %0b",
							m_tdata[3], exp_r.changed));
				end
			end
			if (stall_gap != 0) begin
				stall_gap <= stall_gap - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_gap <= $urandom_range(0, 7);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: a stuck handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Register writes happen only while the block is idle, so the shadow copy is updated
	// at once. Bits above a register's width are dropped by the block.
	task automatic write_reg(input odd_pkg::reg_index_t idx, input logic [23:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			odd_pkg::REG_NORM_MIN:    shadow_cfg.norm_min = value[15:0];
			odd_pkg::REG_NORM_MAX:    shadow_cfg.norm_max = value[15:0];
			odd_pkg::REG_FACE_ENTER:  shadow_cfg.face_enter_cos2 = value[16:0];
			odd_pkg::REG_FACE_EXIT:   shadow_cfg.face_exit_cos2 = value[16:0];
			odd_pkg::REG_ROT_KEEP:    shadow_cfg.rotation_keep_cos2 = value[16:0];
			odd_pkg::REG_STABLE_TIME: shadow_cfg.stable_time_us = value[23:0];
			default: ;
		endcase
	endtask

	// Holds the sender back until every queued item has gone in and every result is out.
	// The check is made between edges, once the sender and receiver have settled.
	task automatic wait_drained();
		@(negedge clk);
		while (sample_pending.size() != 0 || s_tvalid || orient_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int spread(input int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	// Time between samples: mostly a fraction of the reset debounce time, with zero steps
	// allowed and now and then a jump to an arbitrary timestamp.
	function automatic logic [47:0] next_step();
		if ($urandom_range(0, 39) == 0)
			return 48'({$urandom, $urandom});
		return 48'($urandom_range(0, 160000));
	endfunction

	task automatic push_sample(input logic op, input int x, input int y, input int z,
		input logic ok, input logic [47:0] step);
		sample_item_t s;
		clock_us = clock_us + step;
		s.op = op;
		s.ax = x[15:0];
		s.ay = y[15:0];
		s.az = z[15:0];
		s.read_ok = ok;
		s.stamp_us = clock_us;
		sample_pending.push_back(s);
	endtask

	// One plausible sample of a held pose: a rotation pose carries sideways tilt that stays
	// short of the diagonals, a face pose a small x-y part.
	task automatic push_pose(input int pose, input int m);
		int a, b, z;
		if (pose == POSE_UP || pose == POSE_DOWN) begin
			z = (pose == POSE_UP) ? -m : m;
			push_sample(OP_CLASSIFY, spread(m / 2), spread(m / 2), z + spread(m / 8), 1'b1,
				next_step());
		end else begin
			case (pose)
				0:       begin a = spread(m * 4 / 5); b = m + spread(m / 8); end
				1:       begin a = m + spread(m / 8); b = spread(m * 4 / 5); end
				2:       begin a = spread(m * 4 / 5); b = -m + spread(m / 8); end
				default: begin a = -m + spread(m / 8); b = spread(m * 4 / 5); end
			endcase
			push_sample(OP_CLASSIFY, -a, -b, spread(m / 2), 1'b1, next_step());
		end
	endtask

	// Random part: mostly runs of one held pose, the rest arbitrary items including clears,
	// failed reads and out-of-range vectors.
	task automatic push_random(input int count);
		int n, pose, run, m, i;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 99) < 15) begin
				push_sample(($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_CLASSIFY,
					int'($urandom), int'($urandom), int'($urandom), 1'($urandom),
					next_step());
				n++;
			end else begin
				pose = $urandom_range(0, 5);
				run = $urandom_range(1, 8);
				m = $urandom_range(2500, 5500);
				for (i = 0; i < run && n < count; i++) begin
					push_pose(pose, m);
					n++;
				end
			end
		end
	endtask

	// Each new register setting starts from a clear and a few straight up and down samples.
	task automatic push_phase_opening();
		push_sample(OP_CLEAR, 0, 0, 4096, 1'b1, next_step());
		push_sample(OP_CLASSIFY, 0, 0, 4096, 1'b1, next_step());
		push_sample(OP_CLASSIFY, 0, 0, 4096, 1'b1, 48'd400000);
		push_sample(OP_CLASSIFY, 0, 0, -4096, 1'b1, next_step());
		push_sample(OP_CLASSIFY, 0, 0, -4096, 1'b1, 48'd400000);
	endtask

	initial begin
		// Start just short of the timestamp wrap so that it wraps early in the run.
		clock_us = 48'hFFFF_FFF0_0000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset settings.
		push_sample(OP_CLEAR, int'($urandom), int'($urandom), int'($urandom), 1'b1, 48'd0);
		// A failed read is unknown whatever the sample says.
		push_sample(OP_CLASSIFY, 0, 0, -4096, 1'b0, 48'd1000);
		// Magnitude far below and far above the window.
		push_sample(OP_CLASSIFY, 0, 0, 0, 1'b1, 48'd1000);
		push_sample(OP_CLASSIFY, 32767, 32767, 32767, 1'b1, 48'd1000);
		push_sample(OP_CLASSIFY, -32768, -32768, -32768, 1'b1, 48'd1000);
		// Face up becomes reported exactly when the debounce time has passed.
		push_sample(OP_CLASSIFY, 0, 0, -4096, 1'b1, 48'd0);
		push_sample(OP_CLASSIFY, 0, 0, -4096, 1'b1, 48'd150000);
		push_sample(OP_CLASSIFY, 0, 0, -4096, 1'b1, 48'd150000);
		push_sample(OP_CLASSIFY, 0, 0, 4096, 1'b1, 48'd100000);
		push_sample(OP_CLASSIFY, 0, 0, 4096, 1'b1, 48'd300000);
		// The four quarter turns, each held long enough to be reported.
		push_sample(OP_CLASSIFY, 0, -4096, 0, 1'b1, 48'd100000);
		push_sample(OP_CLASSIFY, 0, -4096, 0, 1'b1, 48'd300000);
		push_sample(OP_CLASSIFY, -4096, 0, 0, 1'b1, 48'd100000);
		push_sample(OP_CLASSIFY, -4096, 0, 0, 1'b1, 48'd300000);
		push_sample(OP_CLASSIFY, 0, 4096, 0, 1'b1, 48'd100000);
		push_sample(OP_CLASSIFY, 0, 4096, 0, 1'b1, 48'd300000);
		push_sample(OP_CLASSIFY, 4096, 0, 0, 1'b1, 48'd100000);
		push_sample(OP_CLASSIFY, 4096, 0, 0, 1'b1, 48'd300000);
		// An exact diagonal rounds on to the next quarter turn.
		push_sample(OP_CLASSIFY, -2896, -2896, 0, 1'b1, 48'd100000);
		push_sample(OP_CLASSIFY, -2896, -2896, 0, 1'b1, 48'd300000);
		// Fifty degrees off the reported turn stays inside the keep angle.
		push_sample(OP_CLASSIFY, -2633, -3138, 0, 1'b1, 48'd100000);
		push_sample(OP_CLASSIFY, -2633, -3138, 0, 1'b1, 48'd300000);
		push_sample(OP_CLEAR, 0, 0, 0, 1'b0, 48'd100000);
		push_random(200);
		// Let the pipeline run dry once in the middle of a setting.
		wait_drained();
		push_random(200);
		wait_drained();

		// Face entry for any nonzero z, face exit never, rotation kept up to a right angle off, no
		// debounce; the magnitude window is as wide as the registers allow.
		write_reg(odd_pkg::REG_NORM_MIN, 24'd0);
		write_reg(odd_pkg::REG_NORM_MAX, 24'd65535);
		write_reg(odd_pkg::REG_FACE_ENTER, 24'd0);
		write_reg(odd_pkg::REG_FACE_EXIT, 24'd65536);
		write_reg(odd_pkg::REG_ROT_KEEP, 24'd0);
		write_reg(odd_pkg::REG_STABLE_TIME, 24'd0);
		push_phase_opening();
		push_random(200);
		wait_drained();

		// Face thresholds above one never pass, so a straight up vector has a zero up
		// direction and lands on the second quarter turn; the longest debounce time.
		write_reg(odd_pkg::REG_NORM_MIN, 24'd1000);
		write_reg(odd_pkg::REG_NORM_MAX, 24'd8000);
		write_reg(odd_pkg::REG_FACE_ENTER, 24'd131071);
		write_reg(odd_pkg::REG_FACE_EXIT, 24'd131071);
		write_reg(odd_pkg::REG_ROT_KEEP, 24'd65536);
		write_reg(odd_pkg::REG_STABLE_TIME, 24'hFFFFFF);
		push_phase_opening();
		push_random(200);
		wait_drained();

		// An inverted magnitude window turns every sample into unknown.
		write_reg(odd_pkg::REG_NORM_MIN, 24'd6000);
		write_reg(odd_pkg::REG_NORM_MAX, 24'd2000);
		write_reg(odd_pkg::REG_STABLE_TIME, 24'd1);
		push_phase_opening();
		push_random(150);
		wait_drained();

		// Random settings, with junk above each register's width.
		write_reg(odd_pkg::REG_NORM_MIN, {8'($urandom), 16'($urandom_range(1000, 3000))});
		write_reg(odd_pkg::REG_NORM_MAX, {8'($urandom), 16'($urandom_range(5000, 9000))});
		write_reg(odd_pkg::REG_FACE_ENTER,
			{7'($urandom), 17'($urandom_range(20000, 60000))});
		write_reg(odd_pkg::REG_FACE_EXIT,
			{7'($urandom), 17'($urandom_range(20000, 60000))});
		write_reg(odd_pkg::REG_ROT_KEEP, {7'($urandom), 17'($urandom_range(5000, 40000))});
		write_reg(odd_pkg::REG_STABLE_TIME, 24'($urandom_range(0, 400000)));
		push_phase_opening();
		push_random(200);
		wait_drained();

		// Back to the reset settings for a final stretch at full rate on both sides.
		calm = 1'b1;
		write_reg(odd_pkg::REG_NORM_MIN, 24'd2048);
		write_reg(odd_pkg::REG_NORM_MAX, 24'd6144);
		write_reg(odd_pkg::REG_FACE_ENTER, 24'd43974);
		write_reg(odd_pkg::REG_FACE_EXIT, 24'd32768);
		write_reg(odd_pkg::REG_ROT_KEEP, 24'd16384);
		write_reg(odd_pkg::REG_STABLE_TIME, 24'd300000);
		push_phase_opening();
		push_random(300);
		wait_drained();

		if (err_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
